@@ src/tara_pkg.sv @@
// tara_pkg: shared constants, codes and result layout for the texture atlas
// rectangle allocator.
// No dependencies.
package tara_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int DEF_PAGE_WIDTH    = 512;
    localparam int DEF_PAGE_HEIGHT   = 256;
    localparam int DEF_NUM_PAGES     = 2;
    localparam int DEF_X_START       = 512;
    localparam int DEF_TEXPAGE_WIDTH = 64;
    localparam int DEF_MIP_LEVELS    = 4;

    localparam int LARGE_LIMIT = 256;
    localparam int XSTEP       = 4;
    localparam int SCAN_CHUNK  = 16;
    localparam int OFF_W       = 6;

    localparam logic [9:0] TP_X_MASK = 10'h3C0;
    localparam logic [8:0] TP_Y_MASK = 9'h100;

    // Field widths
    localparam int SIZE_W      = 11;
    localparam int SLOT_W_W    = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_FIELD_W = 77;

    // Configuration port
    localparam int               CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd1;
    localparam logic [SIZE_W-1:0]    MAX_SIZE_RESET = 11'd64;

    // Result payload, mip_level in the lowest bits
    typedef struct packed {
        logic [10:0] slot_height;
        logic [9:0]  slot_width;
        logic [7:0]  tex_v;
        logic [7:0]  tex_u;
        logic [8:0]  tpage_y_base;
        logic [9:0]  tpage_x_base;
        logic [8:0]  row;
        logic [8:0]  column;
        logic        page_index;
        logic [1:0]  mip_level;
    } t_out_data;

endpackage

@@ src/texture_atlas_rect_allocator_top.sv @@
// texture_atlas_rect_allocator_top: mip selection and first-fit rectangle
// placement over an occupancy bitmap held in a single-port column memory.
// Depends on tara_pkg.
//
// Channel   Direction  Handshake                        Content
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tex_width, tex_height; tuser large
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  placement fields; tuser found
// cfg       in         i_cfg_valid/o_cfg_ready          register index, 11-bit value
//
// After reset a clearing pass zeroes all NUM_PAGES*PAGE_WIDTH map words (1024 by default);
// requests wait, configuration writes are taken.
// One request at a time: the mip pick, then per probed column position a setup
// step, w memory reads, shifter passes over the bits of the height and a scan in
// 16-row chunks; a hit adds the mask steps and a read-modify-write of the w
// columns. The single memory port and the shared shift unit set this sequence.
// A finished result waits in the output register; a stalled output holds the
// block in its final state until the register frees.
module texture_atlas_rect_allocator_top #(
    parameter int PAGE_WIDTH    = tara_pkg::DEF_PAGE_WIDTH,
    parameter int PAGE_HEIGHT   = tara_pkg::DEF_PAGE_HEIGHT,
    parameter int NUM_PAGES     = tara_pkg::DEF_NUM_PAGES,
    parameter int X_START       = tara_pkg::DEF_X_START,
    parameter int TEXPAGE_WIDTH = tara_pkg::DEF_TEXPAGE_WIDTH,
    parameter int MIP_LEVELS    = tara_pkg::DEF_MIP_LEVELS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tex_width [10:0], tex_height [21:11], zero [23:22]
    input  logic [tara_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // large_texture [0]
    input  logic [0:0]                         i_s_axis_tuser,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // mip_level [1:0], page_index [2], column [11:3], row [20:12],
    // tpage_x_base [30:21], tpage_y_base [39:31], tex_u [47:40], tex_v [55:48],
    // slot_width [65:56], slot_height [76:66], zero [79:77]
    output logic [tara_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // found [0]
    output logic [0:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tara_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tara_pkg::SIZE_W-1:0]        i_cfg_data
);

    localparam int DEPTH  = NUM_PAGES * PAGE_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = $clog2(PAGE_WIDTH + tara_pkg::XSTEP);
    localparam int HW     = $clog2(PAGE_HEIGHT + 1);
    localparam int BW     = $clog2(HW);
    localparam int YW     = $clog2(PAGE_HEIGHT);
    localparam int PGW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LVW    = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
    localparam int NCHUNK = (PAGE_HEIGHT + tara_pkg::SCAN_CHUNK - 1) / tara_pkg::SCAN_CHUNK;
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int ENCW   = $clog2(tara_pkg::SCAN_CHUNK);
    localparam int SUMW   = $clog2(PAGE_WIDTH + TEXPAGE_WIDTH + 2048) + 1;
    localparam int AXW    = $clog2(PAGE_WIDTH + X_START + tara_pkg::XSTEP) + 1;
    localparam int AYW0   = $clog2(NUM_PAGES * PAGE_HEIGHT);
    localparam int AYW    = (AYW0 > 9) ? AYW0 : 9;
    localparam int SW     = tara_pkg::SIZE_W;
    localparam int SLOT_CNT_W = tara_pkg::SLOT_W_W;

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_SHRINK  = 14'b00000000000100,
        S_CAND    = 14'b00000000001000,
        S_RD      = 14'b00000000010000,
        S_ACC     = 14'b00000000100000,
        S_ER_DBL  = 14'b00000001000000,
        S_ER_ADD  = 14'b00000010000000,
        S_FIND    = 14'b00000100000000,
        S_MASK_LO = 14'b00001000000000,
        S_MASK_SH = 14'b00010000000000,
        S_MK_RD   = 14'b00100000000000,
        S_MK_WR   = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    // Control
    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_addr, n_clr_addr;
    logic                   r_out_valid, n_out_valid;
    logic [SW-1:0]          r_max_width, r_max_height;

    // Datapath
    logic [SW-1:0]          r_w, n_w;
    logic [SW-1:0]          r_h, n_h;
    logic                   r_large, n_large;
    logic [LVW-1:0]         r_level, n_level;
    logic [PGW-1:0]         r_pg, n_pg;
    logic [AW-1:0]          r_base, n_base;
    logic [AYW-1:0]         r_ybase, n_ybase;
    logic [XW-1:0]          r_sx, n_sx;
    logic [XW-1:0]          r_col, n_col;
    logic [SLOT_CNT_W-1:0]  r_cnt, n_cnt;
    logic [PAGE_HEIGHT-1:0] r_acc, n_acc;
    logic [PAGE_HEIGHT-1:0] r_vec, n_vec;
    logic [HW-1:0]          r_len, n_len;
    logic [BW-1:0]          r_bit, n_bit;
    logic [CKW-1:0]         r_chunk, n_chunk;
    logic [YW-1:0]          r_sy, n_sy;
    logic                   r_found, n_found;
    tara_pkg::t_out_data    r_out, n_out;
    logic                   r_out_found, n_out_found;

    // Occupancy memory: one word per page column, one bit per row
    logic [PAGE_HEIGHT-1:0] r_occ_mem [DEPTH];
    logic [PAGE_HEIGHT-1:0] r_rdata;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [PAGE_HEIGHT-1:0] mem_wdata;

    // Shared shift unit
    logic [PAGE_HEIGHT-1:0] sh_in, sh_out;
    logic [HW-1:0]          sh_amt;
    logic                   sh_left;

    logic                   in_acc;
    logic                   shrink_go;
    logic [SW-1:0]          lim_w, lim_h;
    logic [SUMW-1:0]        end_x, off_end;
    logic [HW-1:0]          h_lo;
    logic [tara_pkg::SCAN_CHUNK-1:0] low_bits;
    logic [ENCW-1:0]        enc;
    logic [AXW-1:0]         ax;
    logic [AYW-1:0]         ay;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tara_pkg::OUT_TDATA_W - tara_pkg::OUT_FIELD_W){1'b0}}, r_out};
    assign o_m_axis_tuser  = r_out_found;

    assign lim_w     = r_large ? SW'(tara_pkg::LARGE_LIMIT) : r_max_width;
    assign lim_h     = r_large ? SW'(tara_pkg::LARGE_LIMIT) : r_max_height;
    assign shrink_go = ((r_w > lim_w) || (r_h > lim_h)) && (r_w > SW'(2)) && (r_h > SW'(1))
                       && (r_level < LVW'(MIP_LEVELS - 1));

    assign end_x   = SUMW'(r_sx) + SUMW'(r_w);
    assign off_end = SUMW'(r_sx[tara_pkg::OFF_W-1:0]) + SUMW'(r_w);
    assign h_lo    = HW'(r_h);
    assign low_bits = r_vec[tara_pkg::SCAN_CHUNK-1:0];

    always_comb begin
        enc = '0;
        for (int i = tara_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
            if (low_bits[i]) begin
                enc = ENCW'(i);
            end
        end
    end

    assign ax = AXW'(r_sx) + AXW'(X_START);
    assign ay = r_ybase + AYW'(r_sy);

    always_comb begin
        sh_in   = r_vec;
        sh_amt  = HW'(tara_pkg::SCAN_CHUNK);
        sh_left = 1'b0;
        unique case (r_state)
            S_ER_DBL: begin
                sh_amt = r_len;
            end
            S_ER_ADD: begin
                sh_in  = ~r_acc;
                sh_amt = r_len;
            end
            S_MASK_LO: begin
                sh_in   = '1;
                sh_amt  = h_lo;
                sh_left = 1'b1;
            end
            S_MASK_SH: begin
                sh_amt  = HW'(r_sy);
                sh_left = 1'b1;
            end
            default: begin
                sh_in = r_vec;
            end
        endcase
        sh_out = sh_left ? (sh_in << sh_amt) : (sh_in >> sh_amt);
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_w         = r_w;
        n_h         = r_h;
        n_large     = r_large;
        n_level     = r_level;
        n_pg        = r_pg;
        n_base      = r_base;
        n_ybase     = r_ybase;
        n_sx        = r_sx;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_vec       = r_vec;
        n_len       = r_len;
        n_bit       = r_bit;
        n_chunk     = r_chunk;
        n_sy        = r_sy;
        n_found     = r_found;
        n_out       = r_out;
        n_out_found = r_out_found;
        mem_we      = 1'b0;
        mem_addr    = r_base + AW'(r_col);
        mem_wdata   = r_rdata | r_vec;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_w     = i_s_axis_tdata[SW-1:0];
                    n_h     = i_s_axis_tdata[2*SW-1:SW];
                    n_large = i_s_axis_tuser[0];
                    n_level = '0;
                    n_found = 1'b0;
                    n_state = S_SHRINK;
                end
            end
            S_SHRINK: begin
                if (shrink_go) begin
                    n_w     = r_w >> 1;
                    n_h     = r_h >> 1;
                    n_level = r_level + 1'b1;
                end else begin
                    n_w     = r_w >> 1;
                    n_pg    = '0;
                    n_base  = '0;
                    n_ybase = '0;
                    n_sx    = '0;
                    if (r_h > SW'(PAGE_HEIGHT)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CAND;
                    end
                end
            end
            S_CAND: begin
                if (end_x > SUMW'(PAGE_WIDTH)) begin
                    if (r_pg == PGW'(NUM_PAGES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_pg    = r_pg + 1'b1;
                        n_base  = r_base + AW'(PAGE_WIDTH);
                        n_ybase = r_ybase + AYW'(PAGE_HEIGHT);
                        n_sx    = '0;
                    end
                end else if (off_end > SUMW'(2 * TEXPAGE_WIDTH)) begin
                    n_sx = r_sx + XW'(tara_pkg::XSTEP);
                end else begin
                    n_acc = '0;
                    n_col = r_sx;
                    n_cnt = SLOT_CNT_W'(r_w);
                    if (r_w == '0) begin
                        n_vec   = '1;
                        n_len   = '0;
                        n_bit   = BW'(HW - 1);
                        n_state = S_ER_DBL;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = r_acc | r_rdata;
                n_col = r_col + 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SLOT_CNT_W'(1)) begin
                    n_vec   = '1;
                    n_len   = '0;
                    n_bit   = BW'(HW - 1);
                    n_state = S_ER_DBL;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ER_DBL: begin
                n_vec   = r_vec & sh_out;
                n_len   = r_len << 1;
                n_state = S_ER_ADD;
            end
            S_ER_ADD: begin
                if (h_lo[r_bit]) begin
                    n_vec = r_vec & sh_out;
                    n_len = r_len + 1'b1;
                end
                if (r_bit == '0) begin
                    n_chunk = '0;
                    n_state = S_FIND;
                end else begin
                    n_bit   = r_bit - 1'b1;
                    n_state = S_ER_DBL;
                end
            end
            S_FIND: begin
                if (|low_bits) begin
                    n_sy    = YW'({r_chunk, enc});
                    n_found = 1'b1;
                    n_state = S_MASK_LO;
                end else if (r_chunk == CKW'(NCHUNK - 1)) begin
                    n_sx    = r_sx + XW'(tara_pkg::XSTEP);
                    n_state = S_CAND;
                end else begin
                    n_vec   = sh_out;
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_MASK_LO: begin
                n_vec   = ~sh_out;
                n_state = S_MASK_SH;
            end
            S_MASK_SH: begin
                n_vec = sh_out;
                n_col = r_sx;
                n_cnt = SLOT_CNT_W'(r_w);
                if (r_w == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MK_RD;
                end
            end
            S_MK_RD: begin
                n_state = S_MK_WR;
            end
            S_MK_WR: begin
                mem_we = 1'b1;
                n_col  = r_col + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == SLOT_CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MK_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid          = 1'b1;
                    n_out_found          = r_found;
                    n_out.mip_level      = 2'(r_level);
                    n_out.slot_width     = r_w[SLOT_CNT_W-1:0];
                    n_out.slot_height    = r_h;
                    n_out.page_index     = r_found ? r_pg[0] : 1'b0;
                    n_out.column         = r_found ? 9'(r_sx) : 9'd0;
                    n_out.row            = r_found ? 9'(ay) : 9'd0;
                    n_out.tpage_x_base   = r_found ? (10'(ax) & tara_pkg::TP_X_MASK) : 10'd0;
                    n_out.tpage_y_base   = r_found ? (9'(ay) & tara_pkg::TP_Y_MASK) : 9'd0;
                    n_out.tex_u          = r_found ? {1'b0, ax[5:0], 1'b0} : 8'd0;
                    n_out.tex_v          = r_found ? 8'(ay) : 8'd0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
            r_max_width  <= tara_pkg::MAX_SIZE_RESET;
            r_max_height <= tara_pkg::MAX_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == tara_pkg::CFG_MAX_WIDTH) begin
                    r_max_width <= i_cfg_data;
                end else if (i_cfg_index == tara_pkg::CFG_MAX_HEIGHT) begin
                    r_max_height <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_h         <= n_h;
        r_large     <= n_large;
        r_level     <= n_level;
        r_pg        <= n_pg;
        r_base      <= n_base;
        r_ybase     <= n_ybase;
        r_sx        <= n_sx;
        r_col       <= n_col;
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_vec       <= n_vec;
        r_len       <= n_len;
        r_bit       <= n_bit;
        r_chunk     <= n_chunk;
        r_sy        <= n_sy;
        r_found     <= n_found;
        r_out       <= n_out;
        r_out_found <= n_out_found;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_occ_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_occ_mem[mem_addr];
    end

`ifndef SYNTHESIS
    a_mem_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_MK_WR))
        else $error("occupancy write outside clear or mark");

    a_accept_starts_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SHRINK))
        else $error("accepted transaction did not start mip selection");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHRINK) |-> (r_level <= LVW'(MIP_LEVELS - 1)))
        else $error("mip level beyond limit");

    a_run_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ER_DBL || r_state == S_ER_ADD) |-> (r_len <= h_lo))
        else $error("run length exceeds texture height");

    a_hit_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_found) |-> (end_x <= SUMW'(PAGE_WIDTH)))
        else $error("placement crosses page edge");
`endif

endmodule
